### hw/rtl/rate_scaled_clock_rebase_macros.svh
// Assertion macros used by the back end of the clock rebase RTL.
`ifndef RATE_SCALED_CLOCK_REBASE_MACROS_SVH
`define RATE_SCALED_CLOCK_REBASE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define RSCR_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rscr: same-cycle check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define RSCR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rscr: next-cycle check failed");

`endif

### hw/rtl/rscr_pkg.sv
// Shared types, constants and helpers of the scaled virtual clock bank.
package rscr_pkg;

	localparam int NUM_CLOCKS_DEF      = 4;
	localparam int SCALE_FRAC_BITS_DEF = 16;

	localparam int ID_W        = 2;
	localparam int REAL_W      = 63;
	localparam int TIME_W      = 64;
	localparam int SCALE_W     = 32;
	localparam int LOW_W       = 32;
	localparam int NUM_RESCALE = 4;
	localparam int QDEPTH      = 2;

	localparam logic OP_QUERY   = 1'b0;
	localparam logic OP_RESCALE = 1'b1;

	// One queued request after classification.
	typedef struct packed {
		logic                                op;
		logic [ID_W-1:0]                     clock_id;
		logic [REAL_W-1:0]                   real_time;
		logic [NUM_RESCALE-1:0][REAL_W-1:0]  rescale_real;
		logic [SCALE_W-1:0]                  new_scale;
	} req_t;

	// Side data that rides along the multiply pipeline.
	typedef struct packed {
		logic                rebase;
		logic [ID_W-1:0]     clock_id;
		logic [TIME_W-1:0]   fb;
	} tag_t;

	// Rate 1.0 in the fixed point format, saturated when it does not fit.
	function automatic logic [SCALE_W-1:0] scale_one(input int frac);
		if (frac >= SCALE_W)
			return '1;
		return SCALE_W'(1) << frac;
	endfunction

	// Clocks 1 and 3 report only their low word.
	function automatic logic narrow_clock(input logic [ID_W-1:0] id);
		return id[0];
	endfunction

endpackage

### hw/rtl/rscr_front.sv
// Front end: takes requests, drops those that do nothing, packs them for the queue.
module rscr_front import rscr_pkg::*; #(
	parameter int NUM_CLOCKS = NUM_CLOCKS_DEF
) (
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                operation,
	input  logic [ID_W-1:0]     clock_id,
	input  logic [REAL_W-1:0]   real_time,
	input  logic [REAL_W-1:0]   rescale_real_0,
	input  logic [REAL_W-1:0]   rescale_real_1,
	input  logic [REAL_W-1:0]   rescale_real_2,
	input  logic [REAL_W-1:0]   rescale_real_3,
	input  logic [SCALE_W-1:0]  new_scale,
	input  logic                q_full,
	output logic                q_push,
	output req_t                q_data
);

	logic in_range;
	logic keep;

	// Classify: out-of-range queries and zero-rate changes are dropped here
	assign in_range = (32'(clock_id) < 32'(NUM_CLOCKS));
	assign keep     = (operation == OP_QUERY) ? in_range : (new_scale != '0);

	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full && keep;

	// Pack the request
	always_comb begin
		q_data.op              = operation;
		q_data.clock_id        = clock_id;
		q_data.real_time       = real_time;
		q_data.rescale_real[0] = rescale_real_0;
		q_data.rescale_real[1] = rescale_real_1;
		q_data.rescale_real[2] = rescale_real_2;
		q_data.rescale_real[3] = rescale_real_3;
		q_data.new_scale       = new_scale;
	end

endmodule

### hw/rtl/rscr_fifo.sv
// Short request queue between the front end and the execution back end.
module rscr_fifo import rscr_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  req_t  push_data,
	input  logic  pop,
	output logic  full,
	output logic  empty,
	output req_t  head
);

	localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CNT_W = $clog2(QDEPTH + 1);

	req_t             mem_q [QDEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(QDEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_ptr_q];

	// Store the entry
	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_data;
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

### hw/rtl/rscr_mul.sv
// Scaling pipeline: elapsed real time times rate, floored and saturated.
module rscr_mul import rscr_pkg::*; #(
	parameter int SCALE_FRAC_BITS = SCALE_FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                en,
	input  logic [REAL_W-1:0]   d,
	input  logic [SCALE_W-1:0]  scale,
	output logic [REAL_W-1:0]   scaled
);

	localparam int LO_W   = 32;
	localparam int HI_W   = REAL_W - LO_W;
	localparam int PHI_W  = HI_W + SCALE_W;
	localparam int PLO_W  = LO_W + SCALE_W;
	localparam int PROD_W = REAL_W + SCALE_W;

	logic [PHI_W-1:0]  p_hi_s2;
	logic [PLO_W-1:0]  p_lo_s2;
	logic [REAL_W-1:0] scaled_s3;
	logic [PROD_W-1:0] prod;
	logic [PROD_W-1:0] shifted;
	logic              sat;

	// Two partial products, each at most 32 by 32
	always_ff @(posedge clk) begin
		if (en) begin
			p_hi_s2 <= PHI_W'(d[REAL_W-1:LO_W]) * PHI_W'(scale);
			p_lo_s2 <= PLO_W'(d[LO_W-1:0]) * PLO_W'(scale);
		end
	end

	// Combine, drop fraction bits, clamp at the largest positive value
	assign prod    = {p_hi_s2, {LO_W{1'b0}}} + PROD_W'(p_lo_s2);
	assign shifted = prod >> SCALE_FRAC_BITS;
	assign sat     = |shifted[PROD_W-1:REAL_W];

	always_ff @(posedge clk) begin
		if (en)
			scaled_s3 <= sat ? {REAL_W{1'b1}} : shifted[REAL_W-1:0];
	end

	assign scaled = scaled_s3;

endmodule

### hw/rtl/rscr_back.sv
// Back end: clock state, issue control, rebase sequencing and result register.
`include "rate_scaled_clock_rebase_macros.svh"
module rscr_back import rscr_pkg::*; #(
	parameter int NUM_CLOCKS      = NUM_CLOCKS_DEF,
	parameter int SCALE_FRAC_BITS = SCALE_FRAC_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  req_t                      head,
	input  logic                      q_empty,
	output logic                      q_pop,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [TIME_W-1:0]  fake_time
);

	localparam int IDX_W   = (NUM_CLOCKS > 1) ? $clog2(NUM_CLOCKS) : 1;
	localparam int NUM_REB = (NUM_CLOCKS < NUM_RESCALE) ? NUM_CLOCKS : NUM_RESCALE;
	localparam int CNT_W   = (NUM_REB > 1) ? $clog2(NUM_REB) : 1;

	localparam logic [1:0] ST_RUN   = 2'd0;
	localparam logic [1:0] ST_REB   = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;

	// clock state
	logic [REAL_W-1:0]   real_base_q [NUM_CLOCKS];
	logic [TIME_W-1:0]   fake_base_q [NUM_CLOCKS];
	logic [NUM_CLOCKS-1:0] started_q;
	logic [SCALE_W-1:0]  scale_q;

	// control
	logic [1:0]          st_q;
	logic [CNT_W-1:0]    cnt_q;

	// pipeline
	logic                valid_s1, valid_s2, valid_s3;
	tag_t                tag_s1, tag_s2, tag_s3;
	logic [REAL_W-1:0]   d_s1;
	logic [SCALE_W-1:0]  scale_s1;
	logic [REAL_W-1:0]   scaled;

	// output register
	logic                out_valid_q;
	logic [TIME_W-1:0]   fake_time_q;

	// issue signals
	logic                adv;
	logic                iss_valid;
	logic                iss_rebase;
	logic [ID_W-1:0]     iss_id;
	logic [ID_W-1:0]     reb_id;
	logic [REAL_W-1:0]   iss_real;
	logic [IDX_W-1:0]    iss_idx;
	logic [IDX_W-1:0]    wb_idx;
	logic                iss_started;
	logic                below;
	logic [REAL_W-1:0]   iss_d;
	logic [TIME_W-1:0]   iss_fb;
	logic                fire;
	logic                reb_last;
	logic                reb_busy;
	logic [TIME_W-1:0]   sum;
	logic [TIME_W-1:0]   result;

	// Whole pipeline moves when the output register can take a value
	assign adv = !out_valid_q || out_ready;

	assign reb_id   = ID_W'(cnt_q);
	assign reb_last = (cnt_q == CNT_W'(NUM_REB - 1));
	assign reb_busy = (valid_s1 && tag_s1.rebase) || (valid_s2 && tag_s2.rebase)
		|| (valid_s3 && tag_s3.rebase);

	// Select what enters the pipeline this cycle
	always_comb begin
		iss_valid  = 1'b0;
		iss_rebase = 1'b0;
		iss_id     = head.clock_id;
		iss_real   = head.real_time;
		unique case (st_q)
			ST_RUN: begin
				iss_valid = !q_empty && (head.op == OP_QUERY);
			end
			ST_REB: begin
				iss_rebase = 1'b1;
				iss_id     = reb_id;
				iss_real   = head.rescale_real[reb_id];
				iss_valid  = started_q[IDX_W'(reb_id)];
			end
			default: begin
				iss_valid = 1'b0;
			end
		endcase
	end

	// Read state and form elapsed time and base for the addressed clock
	assign iss_idx     = IDX_W'(iss_id);
	assign iss_started = started_q[iss_idx];
	assign below       = iss_real < real_base_q[iss_idx];
	assign iss_d       = (iss_started && !below) ? iss_real - real_base_q[iss_idx] : '0;
	assign iss_fb      = iss_started ? fake_base_q[iss_idx] : TIME_W'(iss_real);
	assign fire        = iss_valid && adv;

	// Final add of base and scaled elapsed, narrow clocks keep the low word
	assign sum    = tag_s3.fb + TIME_W'(scaled);
	assign result = narrow_clock(tag_s3.clock_id) ? TIME_W'(sum[LOW_W-1:0]) : sum;
	assign wb_idx = IDX_W'(tag_s3.clock_id);

	// Update clock state: start, real base moves, rebased fake base lands at full width
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CLOCKS; i++) begin
				real_base_q[i] <= '0;
				fake_base_q[i] <= '0;
			end
			started_q <= '0;
		end else begin
			if (fire) begin
				if (!iss_started) begin
					real_base_q[iss_idx] <= iss_real;
					fake_base_q[iss_idx] <= TIME_W'(iss_real);
					started_q[iss_idx]   <= 1'b1;
				end else if (below || iss_rebase) begin
					real_base_q[iss_idx] <= iss_real;
				end
			end
			if (adv && valid_s3 && tag_s3.rebase)
				fake_base_q[wb_idx] <= sum;
		end
	end

	// Sequence queries and rate changes
	always_comb begin
		q_pop = 1'b0;
		unique case (st_q)
			ST_RUN: begin
				if (!q_empty)
					q_pop = (head.op == OP_QUERY) ? adv : (head.new_scale == scale_q);
			end
			ST_DRAIN: q_pop = !reb_busy;
			default:  q_pop = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_RUN;
			cnt_q   <= '0;
			scale_q <= scale_one(SCALE_FRAC_BITS);
		end else begin
			unique case (st_q)
				ST_RUN: begin
					if (!q_empty && head.op == OP_RESCALE && head.new_scale != scale_q) begin
						st_q  <= ST_REB;
						cnt_q <= '0;
					end
				end
				ST_REB: begin
					if (adv) begin
						if (reb_last) begin
							scale_q <= head.new_scale;
							st_q    <= ST_DRAIN;
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end
				ST_DRAIN: begin
					if (!reb_busy)
						st_q <= ST_RUN;
				end
				default: st_q <= ST_RUN;
			endcase
		end
	end

	// Pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1    <= fire;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			out_valid_q <= valid_s3 && !tag_s3.rebase;
		end
	end

	// Pipeline payload
	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s1.rebase   <= iss_rebase;
			tag_s1.clock_id <= iss_id;
			tag_s1.fb       <= iss_fb;
			d_s1            <= iss_d;
			scale_s1        <= scale_q;
			tag_s2          <= tag_s1;
			tag_s3          <= tag_s2;
			fake_time_q     <= result;
		end
	end

	rscr_mul #(
		.SCALE_FRAC_BITS(SCALE_FRAC_BITS)
	) u_mul (
		.clk    (clk),
		.en     (adv),
		.d      (d_s1),
		.scale  (scale_s1),
		.scaled (scaled)
	);

	assign out_valid = out_valid_q;
	assign fake_time = fake_time_q;

	// The rate may change only on the last rebase issue
	`RSCR_ASSERT_NEXT(a_scale_hold, !(st_q == ST_REB && adv && reb_last), $stable(scale_q))
	// A rebase never reaches write-back once normal issue has resumed
	`RSCR_ASSERT_IMP(a_rebase_drained, valid_s3 && tag_s3.rebase, st_q != ST_RUN)
	// Drain ends as soon as no rebase is in flight
	`RSCR_ASSERT_NEXT(a_drain_exit, st_q == ST_DRAIN && !reb_busy, st_q == ST_RUN)

endmodule

### hw/rtl/rate_scaled_clock_rebase.sv
// A query passes the request queue, the issue register, the partial-product and scaled
// registers, then the output register. Throughput: one query per cycle unless a full output
// register waits on out_ready; a rate change that differs from the current rate holds the back
// end while each running clock is rebased and until the last rebase has left the multiply pipe.
// Reset (arst_n low, asynchronous): all clocks stopped, bases zero, rate 1.0.
module rate_scaled_clock_rebase import rscr_pkg::*; #(
	parameter int NUM_CLOCKS      = NUM_CLOCKS_DEF,
	parameter int SCALE_FRAC_BITS = SCALE_FRAC_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      operation,
	input  logic [ID_W-1:0]           clock_id,
	input  logic [REAL_W-1:0]         real_time,
	input  logic [REAL_W-1:0]         rescale_real_0,
	input  logic [REAL_W-1:0]         rescale_real_1,
	input  logic [REAL_W-1:0]         rescale_real_2,
	input  logic [REAL_W-1:0]         rescale_real_3,
	input  logic [SCALE_W-1:0]        new_scale,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [TIME_W-1:0]  fake_time
);

	logic q_full;
	logic q_empty;
	logic q_push;
	logic q_pop;
	req_t q_data;
	req_t q_head;

	rscr_front #(
		.NUM_CLOCKS(NUM_CLOCKS)
	) u_front (
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.operation      (operation),
		.clock_id       (clock_id),
		.real_time      (real_time),
		.rescale_real_0 (rescale_real_0),
		.rescale_real_1 (rescale_real_1),
		.rescale_real_2 (rescale_real_2),
		.rescale_real_3 (rescale_real_3),
		.new_scale      (new_scale),
		.q_full         (q_full),
		.q_push         (q_push),
		.q_data         (q_data)
	);

	rscr_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_data),
		.pop       (q_pop),
		.full      (q_full),
		.empty     (q_empty),
		.head      (q_head)
	);

	rscr_back #(
		.NUM_CLOCKS      (NUM_CLOCKS),
		.SCALE_FRAC_BITS (SCALE_FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (q_head),
		.q_empty   (q_empty),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.fake_time (fake_time)
	);

endmodule

### tb/tb_rate_scaled_clock_rebase.sv
// Self-checking testbench for the scaled virtual clock bank with rate rebase.
module tb_rate_scaled_clock_rebase;
	import rscr_pkg::*;

	localparam int ITEMS        = 900;
	localparam int CYCLE_LIMIT  = 250000;
	localparam int DRAIN_CYCLES = 24;
	localparam int MAX_REPORTS  = 10;

	localparam logic [SCALE_W-1:0] RATE_ONE = SCALE_W'(1) << SCALE_FRAC_BITS_DEF;
	localparam logic [REAL_W-1:0]  REAL_MAX = '1;
	localparam logic [TIME_W-1:0]  SPAN_MAX = {1'b0, {(TIME_W-1){1'b1}}};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid;
	logic in_ready;
	logic operation;
	logic [ID_W-1:0] clock_id;
	logic [REAL_W-1:0] real_time;
	logic [REAL_W-1:0] rescale_real_0;
	logic [REAL_W-1:0] rescale_real_1;
	logic [REAL_W-1:0] rescale_real_2;
	logic [REAL_W-1:0] rescale_real_3;
	logic [SCALE_W-1:0] new_scale;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [TIME_W-1:0] fake_time;

	// Predicted clock bank state
	logic [TIME_W-1:0] real_base [4];
	logic [TIME_W-1:0] fake_base [4];
	logic started [4];
	logic [SCALE_W-1:0] rate_now;

	logic [TIME_W-1:0] expected_times [$];
	logic [REAL_W-1:0] wall [4];
	int mismatch_count = 0;
	int cycle_count = 0;
	int burst_left = 0;
	int stall_mode = 0;
	int stall_left = 0;

	rate_scaled_clock_rebase dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.clock_id(clock_id),
		.real_time(real_time),
		.rescale_real_0(rescale_real_0),
		.rescale_real_1(rescale_real_1),
		.rescale_real_2(rescale_real_2),
		.rescale_real_3(rescale_real_3),
		.new_scale(new_scale),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.fake_time(fake_time)
	);

	always #5 clk = ~clk;

	// Count cycles and stop a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Stall the result side in changing modes, including stretches of no stall
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_left <= $urandom_range(16, 96);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			0: begin
				out_ready <= 1'b1;
			end
			1: begin
				out_ready <= $urandom_range(0, 1);
			end
			2: begin
				out_ready <= (cycle_count % 7) > 2;
			end
			default: begin
				out_ready <= ($urandom_range(0, 7) != 0);
			end
		endcase
	end

	function automatic logic [REAL_W-1:0] rand63();
		logic [63:0] w;
		w = {$urandom(), $urandom()};
		return w[REAL_W-1:0];
	endfunction

	// Scaled elapsed time: floor(span * rate), saturated to the positive range
	function automatic logic [TIME_W-1:0] scale_span(input logic [REAL_W-1:0] span,
			input logic [SCALE_W-1:0] rate);
		logic [95:0] prod;
		logic [95:0] shifted;
		prod = {33'b0, span} * {64'b0, rate};
		shifted = prod >> SCALE_FRAC_BITS_DEF;
		if (shifted > {32'b0, SPAN_MAX})
			return SPAN_MAX;
		return shifted[TIME_W-1:0];
	endfunction

	// Read one clock at a real value, starting it on first use
	function automatic logic [TIME_W-1:0] clock_reading(input int id,
			input logic [REAL_W-1:0] rt);
		if (!started[id]) begin
			real_base[id] = {1'b0, rt};
			fake_base[id] = {1'b0, rt};
			started[id] = 1'b1;
			return {1'b0, rt};
		end
		if ({1'b0, rt} < real_base[id])
			real_base[id] = {1'b0, rt};
		return fake_base[id] + scale_span(rt - real_base[id][REAL_W-1:0], rate_now);
	endfunction

	// Unless the rate is zero or unchanged, freeze every running clock at the old rate, then switch rate
	function automatic void predict_rescale(input logic [REAL_W-1:0] rr [4],
			input logic [SCALE_W-1:0] rate);
		if (rate == '0 || rate == rate_now)
			return;
		for (int i = 0; i < 4; i++) begin
			if (started[i]) begin
				fake_base[i] = clock_reading(i, rr[i]);
				real_base[i] = {1'b0, rr[i]};
			end
		end
		rate_now = rate;
	endfunction

	function automatic void reset_prediction();
		for (int i = 0; i < 4; i++) begin
			real_base[i] = '0;
			fake_base[i] = '0;
			started[i] = 1'b0;
		end
		rate_now = RATE_ONE;
	endfunction

	task automatic report_mismatch(input string what, input logic [TIME_W-1:0] want,
			input logic [TIME_W-1:0] got);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("ERROR %s: expected %h, got %h", what, want, got);
	endtask

	// Check each accepted result against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_times.size() == 0)
				report_mismatch("unexpected result", 'x, fake_time);
			else if (fake_time !== expected_times[0])
				report_mismatch("fake_time", expected_times[0], fake_time);
			if (expected_times.size() != 0)
				void'(expected_times.pop_front());
		end
	end

	// Send one request in bursts with random gaps, then predict its outcome
	task automatic send_request(input logic op, input logic [ID_W-1:0] id,
			input logic [REAL_W-1:0] rt, input logic [REAL_W-1:0] r0,
			input logic [REAL_W-1:0] r1, input logic [REAL_W-1:0] r2,
			input logic [REAL_W-1:0] r3, input logic [SCALE_W-1:0] rate);
		int gap;
		logic [TIME_W-1:0] reading;
		logic [REAL_W-1:0] rr [4];
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		burst_left--;
		in_valid <= 1'b1;
		operation <= op;
		clock_id <= id;
		real_time <= rt;
		rescale_real_0 <= r0;
		rescale_real_1 <= r1;
		rescale_real_2 <= r2;
		rescale_real_3 <= r3;
		new_scale <= rate;
		do @(posedge clk); while (!in_ready);
		if (op == OP_QUERY) begin
			reading = clock_reading(id, rt);
			if (id[0])
				reading = {32'b0, reading[31:0]};
			expected_times.push_back(reading);
		end else begin
			rr[0] = r0;
			rr[1] = r1;
			rr[2] = r2;
			rr[3] = r3;
			predict_rescale(rr, rate);
		end
	endtask

	// Query with noise on the unused fields
	task automatic query_clock(input logic [ID_W-1:0] id, input logic [REAL_W-1:0] rt);
		send_request(OP_QUERY, id, rt, rand63(), rand63(), rand63(), rand63(), $urandom());
	endtask

	// Rate change with noise on the unused fields
	task automatic rescale_clocks(input logic [REAL_W-1:0] r0, input logic [REAL_W-1:0] r1,
			input logic [REAL_W-1:0] r2, input logic [REAL_W-1:0] r3,
			input logic [SCALE_W-1:0] rate);
		send_request(OP_RESCALE, ID_W'($urandom()), rand63(), r0, r1, r2, r3, rate);
	endtask

	// First query of each clock echoes the real value, only its low word for clocks 1 and 3
	task automatic test_clock_start();
		query_clock(0, REAL_MAX);
		query_clock(1, 63'h7FFF_FFFF_1234_5678);
		query_clock(2, '0);
		query_clock(3, 63'h0000_0001_0000_0000);
	endtask

	// Elapsed time at rate 1.0, a real value below the base, and a wrapping sum
	task automatic test_elapsed_and_backward();
		query_clock(2, 63'd1000);
		query_clock(1, 63'h7FFF_FFFF_1234_567D);
		query_clock(0, 63'd5);
		query_clock(0, 63'd10);
		query_clock(3, '0);
		query_clock(3, 63'h0000_0002_8000_0000);
	endtask

	// Zero or unchanged rate leaves everything alone
	task automatic test_ignored_rescale();
		rescale_clocks(63'd1, 63'd1, 63'd1, 63'd1, '0);
		rescale_clocks(63'd1, 63'd1, 63'd1, 63'd1, RATE_ONE);
		query_clock(2, 63'd2000);
	endtask

	// Rebase at a new rate, saturate at the largest rate, floor at the smallest
	task automatic test_rate_change();
		rescale_clocks(63'd20, 63'h7FFF_FFFF_1234_5680, 63'd3000, 63'h0000_0002_8000_0001,
			32'h0000_8000);
		query_clock(2, 63'd4001);
		query_clock(0, 63'd19);
		rescale_clocks(63'd30, 63'h7FFF_FFFF_1234_5690, 63'd3000, 63'h0000_0002_8000_0004,
			32'hFFFF_FFFF);
		query_clock(2, REAL_MAX);
		query_clock(3, 63'h0000_0002_8001_0000);
		rescale_clocks(63'd40, 63'h7FFF_FFFF_1234_56A0, 63'd5000, 63'h0000_0002_8001_0001,
			32'h0000_0001);
		query_clock(2, 63'd5000 + 63'd200000);
		query_clock(1, REAL_MAX);
		rescale_clocks(63'd50, REAL_MAX, 63'd9000, 63'h0000_0002_8002_0000, RATE_ONE);
	endtask

	// Move a clock's real value: mostly forward, sometimes back or anywhere
	function automatic logic [REAL_W-1:0] advance_wall(input int id);
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 60)
			wall[id] += $urandom_range(0, 5000);
		else if (pick < 70)
			wall[id] -= $urandom_range(1, 5000);
		else if (pick < 78)
			wall[id] += rand63() >> $urandom_range(8, 40);
		else if (pick < 86)
			wall[id] = rand63();
		else if (pick < 92)
			wall[id] = REAL_MAX - $urandom_range(0, 100);
		return wall[id];
	endfunction

	function automatic logic [SCALE_W-1:0] pick_rate();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 8)
			return '0;
		if (pick < 16)
			return rate_now;
		if (pick < 26)
			return $urandom();
		return $urandom_range(32'h0000_0100, 32'h0004_0000);
	endfunction

	// Random mix of queries and rate changes that track each clock's real value
	task automatic test_random_traffic();
		logic [REAL_W-1:0] rr [4];
		for (int i = 0; i < 4; i++)
			wall[i] = real_base[i][REAL_W-1:0];
		for (int n = 0; n < ITEMS; n++) begin
			if ($urandom_range(0, 99) < 12) begin
				for (int i = 0; i < 4; i++)
					rr[i] = ($urandom_range(0, 99) < 85) ? advance_wall(i) : rand63();
				rescale_clocks(rr[0], rr[1], rr[2], rr[3], pick_rate());
			end else begin
				int id;
				id = $urandom_range(0, 3);
				query_clock(ID_W'(id), advance_wall(id));
			end
		end
	endtask

	initial begin
		in_valid <= 1'b0;
		operation <= OP_QUERY;
		clock_id <= '0;
		real_time <= '0;
		rescale_real_0 <= '0;
		rescale_real_1 <= '0;
		rescale_real_2 <= '0;
		rescale_real_3 <= '0;
		new_scale <= '0;
		reset_prediction();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_clock_start();
		test_elapsed_and_backward();
		test_ignored_rescale();
		test_rate_change();
		test_random_traffic();

		// Drain outstanding results, then let any stray output show up
		in_valid <= 1'b0;
		while (expected_times.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
